### rtl/lpr_pkg.sv
// Shared types and constants of the line point rasterizer.
package lpr_pkg;

   localparam int FIELD_BITS = 6;
   localparam int LAYER_BITS = 4;

   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 32;

   // Register index, taken from paddr[2].
   localparam logic REG_LAST_COLUMN = 1'b0;
   localparam logic REG_LAST_ROW    = 1'b1;

   localparam logic [FIELD_BITS-1:0] RESET_LAST_COLUMN = 6'd63;
   localparam logic [FIELD_BITS-1:0] RESET_LAST_ROW    = 6'd23;

   localparam int QUEUE_DEPTH = 2;

   typedef struct packed {
      logic [LAYER_BITS-1:0] layer_sel;
      logic [FIELD_BITS-1:0] start_col;
      logic [FIELD_BITS-1:0] start_row;
      logic [FIELD_BITS-1:0] end_col;
      logic [FIELD_BITS-1:0] end_row;
   } lpr_req_type;

   // One classified line: lower major endpoint, its minor coordinate and the deltas.
   typedef struct packed {
      logic [LAYER_BITS-1:0]      layer;
      logic                       xmajor;
      logic [FIELD_BITS-1:0]      maj0;
      logic [FIELD_BITS-1:0]      min0;
      logic [FIELD_BITS-1:0]      dmaj;
      logic signed [FIELD_BITS:0] dmin;
   } lpr_cmd_type;

   typedef struct packed {
      logic [FIELD_BITS-1:0] last_column;
      logic [FIELD_BITS-1:0] last_row;
   } lpr_clip_type;

endpackage

### rtl/lpr_front.sv
// Front end: picks the major axis, orders the endpoints and forms the deltas.
module lpr_front #(
   parameter int COORD_BITS = 6
) (
   input  lpr_pkg::lpr_req_type req,
   output lpr_pkg::lpr_cmd_type cmd
);
   import lpr_pkg::*;

   localparam int C = COORD_BITS;

   logic [C-1:0]        c0, r0, c1, r1;
   logic signed [C:0]   dc, dr, neg_dc, neg_dr;
   logic [C-1:0]        adc, adr;
   logic                xmajor;
   logic [C-1:0]        a_maj, a_min, b_maj, b_min;
   logic                swap;
   logic [C-1:0]        maj0, min0, maj1, min1;
   logic [C-1:0]        dmaj;
   logic signed [C:0]   dmin;

   always_comb begin
      c0 = req.start_col[C-1:0];
      r0 = req.start_row[C-1:0];
      c1 = req.end_col[C-1:0];
      r1 = req.end_row[C-1:0];

      dc     = $signed({1'b0, c1}) - $signed({1'b0, c0});
      dr     = $signed({1'b0, r1}) - $signed({1'b0, r0});
      neg_dc = -dc;
      neg_dr = -dr;
      adc    = dc[C] ? neg_dc[C-1:0] : dc[C-1:0];
      adr    = dr[C] ? neg_dr[C-1:0] : dr[C-1:0];

      // equal deltas count as x-major
      xmajor = (adc >= adr);

      a_maj = xmajor ? c0 : r0;
      a_min = xmajor ? r0 : c0;
      b_maj = xmajor ? c1 : r1;
      b_min = xmajor ? r1 : c1;

      // walk always runs from the lower major coordinate upward
      swap = (a_maj > b_maj);
      maj0 = swap ? b_maj : a_maj;
      min0 = swap ? b_min : a_min;
      maj1 = swap ? a_maj : b_maj;
      min1 = swap ? a_min : b_min;

      dmaj = maj1 - maj0;
      dmin = $signed({1'b0, min1}) - $signed({1'b0, min0});

      cmd.layer  = req.layer_sel;
      cmd.xmajor = xmajor;
      cmd.maj0   = FIELD_BITS'(maj0);
      cmd.min0   = FIELD_BITS'(min0);
      cmd.dmaj   = FIELD_BITS'(dmaj);
      cmd.dmin   = (FIELD_BITS + 1)'(dmin);
   end

endmodule

### rtl/lpr_queue.sv
// Short command queue between the front end and the point walker.
module lpr_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  lpr_pkg::lpr_cmd_type push_data,
   output logic                 full,
   input  logic                 pop,
   output lpr_pkg::lpr_cmd_type pop_data,
   output logic                 nonempty
);
   import lpr_pkg::*;

   localparam int PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

   lpr_cmd_type         slots_ff [QUEUE_DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0] count_ff, count_in;
   logic                do_push, do_pop;

   always_comb begin
      full     = (count_ff == CNT_BITS'(QUEUE_DEPTH));
      nonempty = (count_ff != '0);
      pop_data = slots_ff[rd_ptr_ff];
      do_push  = push && !full;
      do_pop   = pop && nonempty;

      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

### rtl/lpr_walk.sv
// Back end: steps along the major axis and emits one registered point per cycle while the output register is free.
module lpr_walk #(
   parameter int COORD_BITS = 6
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  lpr_pkg::lpr_clip_type                 clip,
   input  logic                                  cmd_valid,
   input  lpr_pkg::lpr_cmd_type                  cmd,
   output logic                                  cmd_pop,
   output logic                                  pt_valid,
   input  logic                                  pt_ready,
   output logic [lpr_pkg::FIELD_BITS-1:0]        pt_col,
   output logic [lpr_pkg::FIELD_BITS-1:0]        pt_row,
   output logic                                  pt_on_screen,
   output logic [lpr_pkg::LAYER_BITS-1:0]        pt_layer,
   output logic                                  pt_last
);
   import lpr_pkg::*;

   localparam int C = COORD_BITS;

   // walker state
   logic                    active_ff, active_in;
   logic                    xmajor_ff, xmajor_in;
   logic [C-1:0]            maj_ff, maj_in;
   logic [C-1:0]            min_ff, min_in;
   logic [C-1:0]            cnt_ff, cnt_in;
   logic signed [C+2:0]     err_ff, err_in;
   logic signed [C+2:0]     dmin2_ff, dmin2_in;
   logic signed [C+2:0]     dmaj2_ff, dmaj2_in;
   logic [LAYER_BITS-1:0]   layer_ff, layer_in;

   // output stage
   logic                    out_valid_ff, out_valid_in;
   logic [FIELD_BITS-1:0]   out_col_ff, out_col_in;
   logic [FIELD_BITS-1:0]   out_row_ff, out_row_in;
   logic                    out_vis_ff, out_vis_in;
   logic [LAYER_BITS-1:0]   out_layer_ff, out_layer_in;
   logic                    out_last_ff, out_last_in;

   logic                    slot_free, emit;
   logic signed [C:0]       cmd_dmin;
   logic signed [C+2:0]     dmin_ext;
   logic signed [C+2:0]     err_step;
   logic [FIELD_BITS-1:0]   cur_col, cur_row;

   always_comb begin
      slot_free = !out_valid_ff || pt_ready;
      emit      = active_ff && slot_free;
      cmd_pop   = !active_ff && cmd_valid;

      cmd_dmin  = cmd.dmin[C:0];
      dmin_ext  = (C + 3)'(cmd_dmin);
      err_step  = err_ff + dmin2_ff;

      cur_col   = FIELD_BITS'(xmajor_ff ? maj_ff : min_ff);
      cur_row   = FIELD_BITS'(xmajor_ff ? min_ff : maj_ff);

      active_in = active_ff;
      xmajor_in = xmajor_ff;
      maj_in    = maj_ff;
      min_in    = min_ff;
      cnt_in    = cnt_ff;
      err_in    = err_ff;
      dmin2_in  = dmin2_ff;
      dmaj2_in  = dmaj2_ff;
      layer_in  = layer_ff;

      out_valid_in = out_valid_ff;
      out_col_in   = out_col_ff;
      out_row_in   = out_row_ff;
      out_vis_in   = out_vis_ff;
      out_layer_in = out_layer_ff;
      out_last_in  = out_last_ff;

      if (cmd_pop) begin
         // remainder starts at D, so the minor offset rounds half up
         active_in = 1'b1;
         xmajor_in = cmd.xmajor;
         maj_in    = cmd.maj0[C-1:0];
         min_in    = cmd.min0[C-1:0];
         cnt_in    = cmd.dmaj[C-1:0];
         err_in    = (C + 3)'(cmd.dmaj[C-1:0]);
         dmaj2_in  = (C + 3)'({cmd.dmaj[C-1:0], 1'b0});
         dmin2_in  = dmin_ext <<< 1;
         layer_in  = cmd.layer;
      end

      if (emit) begin
         out_valid_in = 1'b1;
         out_col_in   = cur_col;
         out_row_in   = cur_row;
         out_vis_in   = (cur_col <= clip.last_column) && (cur_row <= clip.last_row);
         out_layer_in = layer_ff;
         out_last_in  = (cnt_ff == '0);

         if (cnt_ff == '0) begin
            active_in = 1'b0;
         end else begin
            maj_in = maj_ff + 1'b1;
            cnt_in = cnt_ff - 1'b1;
            err_in = err_step;
            // one correction suffices since |2*dmin| <= 2*D
            if (!dmin2_ff[C+2]) begin
               if (err_step >= dmaj2_ff) begin
                  err_in = err_step - dmaj2_ff;
                  min_in = min_ff + 1'b1;
               end
            end else if (err_step[C+2]) begin
               err_in = err_step + dmaj2_ff;
               min_in = min_ff - 1'b1;
            end
         end
      end else if (pt_ready) begin
         out_valid_in = 1'b0;
      end

      pt_valid     = out_valid_ff;
      pt_col       = out_col_ff;
      pt_row       = out_row_ff;
      pt_on_screen = out_vis_ff;
      pt_layer     = out_layer_ff;
      pt_last      = out_last_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         active_ff    <= active_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      xmajor_ff    <= xmajor_in;
      maj_ff       <= maj_in;
      min_ff       <= min_in;
      cnt_ff       <= cnt_in;
      err_ff       <= err_in;
      dmin2_ff     <= dmin2_in;
      dmaj2_ff     <= dmaj2_in;
      layer_ff     <= layer_in;
      out_col_ff   <= out_col_in;
      out_row_ff   <= out_row_in;
      out_vis_ff   <= out_vis_in;
      out_layer_ff <= out_layer_in;
      out_last_ff  <= out_last_in;
   end

endmodule

### rtl/line_point_rasterizer.sv
// Top level of the DDA line point rasterizer with its clip register port.
//
// Usage: each transfer on the req_ stream carries one line (two endpoints and
// a layer number). The block answers on the rsp_ stream with every grid point
// of that line, one transfer per major-axis step, from the lower to the higher
// major coordinate; rsp_tlast marks the final point and rsp_tuser flags points
// inside the clip window set through the APB-style port (last_column at 0x0,
// last_row at 0x4).
// Flow: a line accepted into an idle block passes through the command queue
// and is loaded into the point walker; its points leave from the output
// register. After the load the walker emits one point per cycle while the
// output register drains, and it takes no new line until the current one ends.
// A two-entry command queue lets the input side take further lines while the walker is busy.
// Reset clears the queue, the walker and the output register and loads the
// clip bounds with 63 and 23. When the receiver holds rsp_tready low, the
// current point is held in the output register, the walker stops, and req_tready
// drops once the queue is full.
module line_point_rasterizer #(
   parameter int COORD_BITS = 6
) (
   input  logic                               clock,
   input  logic                               reset,
   // input stream
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // [3:0] layer_sel, [9:4] start_col, [15:10] start_row,
   // [21:16] end_col, [27:22] end_row, [31:28] zero
   input  logic [31:0]                        req_tdata,
   // result stream
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // [5:0] point_col, [11:6] point_row, [15:12] layer_out
   output logic [15:0]                        rsp_tdata,
   // [0] on_screen
   output logic                               rsp_tuser,
   output logic                               rsp_tlast,
   // register port
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [lpr_pkg::CSR_ADDR_BITS-1:0]  paddr,
   input  logic [lpr_pkg::CSR_DATA_BITS-1:0]  pwdata,
   output logic [lpr_pkg::CSR_DATA_BITS-1:0]  prdata,
   output logic                               pready
);
   import lpr_pkg::*;

   // clip bounds
   logic [FIELD_BITS-1:0] last_column_ff, last_column_in;
   logic [FIELD_BITS-1:0] last_row_ff, last_row_in;
   logic                  csr_write;
   logic                  csr_index;
   lpr_clip_type          clip;

   lpr_req_type           req;
   lpr_cmd_type           front_cmd, queue_cmd;
   logic                  queue_full, queue_nonempty, queue_pop;

   logic [FIELD_BITS-1:0] pt_col, pt_row;
   logic [LAYER_BITS-1:0] pt_layer;
   logic                  pt_on_screen;

   // Register port: write in the access phase, reads return the live value.
   always_comb begin
      pready    = 1'b1;
      csr_write = psel && penable && pwrite && pready;
      csr_index = paddr[2];

      last_column_in = last_column_ff;
      last_row_in    = last_row_ff;
      prdata         = '0;
      case (csr_index)
         REG_LAST_COLUMN: begin
            prdata = CSR_DATA_BITS'(last_column_ff);
            if (csr_write) begin
               last_column_in = pwdata[FIELD_BITS-1:0];
            end
         end
         REG_LAST_ROW: begin
            prdata = CSR_DATA_BITS'(last_row_ff);
            if (csr_write) begin
               last_row_in = pwdata[FIELD_BITS-1:0];
            end
         end
         default: begin
            prdata = '0;
         end
      endcase

      clip.last_column = last_column_ff;
      clip.last_row    = last_row_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_column_ff <= RESET_LAST_COLUMN;
         last_row_ff    <= RESET_LAST_ROW;
      end else begin
         last_column_ff <= last_column_in;
         last_row_ff    <= last_row_in;
      end
   end

   // Unpack the input transfer.
   always_comb begin
      req.layer_sel = req_tdata[3:0];
      req.start_col = req_tdata[9:4];
      req.start_row = req_tdata[15:10];
      req.end_col   = req_tdata[21:16];
      req.end_row   = req_tdata[27:22];
      req_tready    = !queue_full;
   end

   lpr_front #(
      .COORD_BITS (COORD_BITS)
   ) u_front (
      .req (req),
      .cmd (front_cmd)
   );

   lpr_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_tvalid),
      .push_data (front_cmd),
      .full      (queue_full),
      .pop       (queue_pop),
      .pop_data  (queue_cmd),
      .nonempty  (queue_nonempty)
   );

   lpr_walk #(
      .COORD_BITS (COORD_BITS)
   ) u_walk (
      .clock        (clock),
      .reset        (reset),
      .clip         (clip),
      .cmd_valid    (queue_nonempty),
      .cmd          (queue_cmd),
      .cmd_pop      (queue_pop),
      .pt_valid     (rsp_tvalid),
      .pt_ready     (rsp_tready),
      .pt_col       (pt_col),
      .pt_row       (pt_row),
      .pt_on_screen (pt_on_screen),
      .pt_layer     (pt_layer),
      .pt_last      (rsp_tlast)
   );

   // Pack the result transfer.
   always_comb begin
      rsp_tdata = {pt_layer, pt_row, pt_col};
      rsp_tuser = pt_on_screen;
   end

endmodule

### rtl/lpr_checker.sv
// Port-level checks of the line point rasterizer and their bind.
module lpr_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata,
   input logic        rsp_tuser,
   input logic        rsp_tlast,
   input logic        psel,
   input logic        penable,
   input logic        pwrite,
   input logic [2:0]  paddr,
   input logic [31:0] pwdata,
   input logic [31:0] prdata,
   input logic        pready
);
   import lpr_pkg::*;

   logic       mid_line_ff, mid_line_in;
   logic [3:0] prev_layer_ff, prev_layer_in;
   logic       rsp_xfer;
   logic       wr_col;

   always_comb begin
      rsp_xfer      = rsp_tvalid && rsp_tready;
      wr_col        = psel && penable && pwrite && pready && (paddr[2] == REG_LAST_COLUMN);
      mid_line_in   = mid_line_ff;
      prev_layer_in = prev_layer_ff;
      if (rsp_xfer) begin
         mid_line_in   = !rsp_tlast;
         prev_layer_in = rsp_tdata[15:12];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mid_line_ff <= 1'b0;
      end else begin
         mid_line_ff <= mid_line_in;
      end
      prev_layer_ff <= prev_layer_in;
   end

   // reset empties the output register and the queue
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && req_tready)
      else $error("output valid or input stalled right after reset");

   // a stalled point holds
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("stalled point changed");

   // every point of one line carries the same layer
   a_layer_steady: assert property (@(posedge clock) disable iff (reset)
      rsp_xfer && mid_line_ff |-> rsp_tdata[15:12] == prev_layer_ff)
      else $error("layer changed inside a line");

   // a written clip column reads back
   a_column_readback: assert property (@(posedge clock) disable iff (reset)
      wr_col ##1 (paddr[2] == REG_LAST_COLUMN) |-> prdata == {26'd0, $past(pwdata[5:0])})
      else $error("last_column readback mismatch");

endmodule

bind line_point_rasterizer lpr_checker u_lpr_checker (.*);
